### hw/rtl/lcd4_pkg.sv
// ============================================================================
// lcd4_pkg
// Types, codes and constants shared by the character LCD write sequencer.
// ============================================================================
package lcd4_pkg;

    // Request kinds
    localparam logic [1:0] KIND_INIT   = 2'd0;
    localparam logic [1:0] KIND_CMD    = 2'd1;
    localparam logic [1:0] KIND_DATA   = 2'd2;
    localparam logic [1:0] KIND_CURSOR = 2'd3;

    // Configuration register indexes
    localparam int unsigned   CFG_INDEX_W          = 2;
    localparam logic [1:0]    REG_ENABLE_HOLD      = 2'd0;
    localparam logic [1:0]    REG_POWER_UP_WAIT    = 2'd1;
    localparam logic [1:0]    REG_INIT_STEP_WAIT   = 2'd2;

    localparam logic [15:0]   ENABLE_HOLD_RESET    = 16'd2000;
    localparam logic [15:0]   POWER_UP_WAIT_RESET  = 16'd40000;
    localparam logic [15:0]   INIT_STEP_WAIT_RESET = 16'd50000;

    // Protocol constants
    localparam logic [3:0]  INIT_NIBBLE_FIRST   = 4'h3;
    localparam logic [3:0]  INIT_NIBBLE_SECOND  = 4'h2;
    localparam logic [15:0] AFTER_FIRST_INIT_US = 16'd2000;
    localparam logic [7:0]  CMD_SET_DDRAM       = 8'h80;
    localparam logic [7:0]  ROW2_OFFSET         = 8'h40;
    localparam logic [7:0]  COLUMN_LIMIT        = 8'd40;

    // Step counter width and last step index per operation
    localparam int unsigned STEP_W        = 4;
    localparam logic [3:0]  INIT_LAST_STEP = 4'd11;
    localparam logic [3:0]  BYTE_LAST_STEP = 4'd1;

    localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] byte_value;
        logic [7:0] column;
        logic [7:0] row;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  nibble;
        logic        register_select;
        logic [15:0] settle_before_us;
        logic [15:0] enable_high_us;
        logic [15:0] settle_after_us;
        logic        last;
    } out_item_t;

    typedef enum logic {
        OP_BYTE = 1'b0,
        OP_INIT = 1'b1
    } op_kind_t;

    // One classified operation waiting for the back end
    typedef struct packed {
        op_kind_t   op;
        logic [7:0] byte_value;
        logic       register_select;
    } op_t;

    typedef struct packed {
        logic [15:0] enable_hold_us;
        logic [15:0] power_up_wait_us;
        logic [15:0] init_step_wait_us;
    } cfg_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

    // Command bytes sent after the two wake-up nibbles
    function automatic logic [7:0] init_cmd(input logic [2:0] idx);
        logic [7:0] cmd;
        case (idx)
            3'd0:    cmd = 8'h28;
            3'd1:    cmd = 8'h0E;
            3'd2:    cmd = 8'h01;
            3'd3:    cmd = 8'h06;
            3'd4:    cmd = 8'h80;
            default: cmd = 8'h00;
        endcase
        return cmd;
    endfunction

endpackage

### hw/rtl/lcd4_front.sv
// ============================================================================
// lcd4_front
// Classifies requests into operations and drops out-of-range cursor moves.
// ============================================================================
module lcd4_front (
    input  logic             start,
    input  logic             busy,
    input  lcd4_pkg::in_item_t request,
    output logic             push,
    output lcd4_pkg::op_t    push_data
);
    import lcd4_pkg::*;

    logic       accept;
    logic [7:0] cursor_cmd;

    assign accept     = start && !busy;
    assign cursor_cmd = CMD_SET_DDRAM | request.column
                        | ((request.row != 8'd0) ? ROW2_OFFSET : 8'd0);

    always_comb
    begin
        push                      = 1'b0;
        push_data.op              = OP_BYTE;
        push_data.byte_value      = request.byte_value;
        push_data.register_select = 1'b0;
        case (request.kind)
            KIND_INIT:
            begin
                push         = accept;
                push_data.op = OP_INIT;
            end
            KIND_CMD:
            begin
                push = accept;
            end
            KIND_DATA:
            begin
                push                      = accept;
                push_data.register_select = 1'b1;
            end
            KIND_CURSOR:
            begin
                // drop a move past the end of the line
                push                 = accept && (request.column < COLUMN_LIMIT);
                push_data.byte_value = cursor_cmd;
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

endmodule

### hw/rtl/lcd4_queue.sv
// ============================================================================
// lcd4_queue
// Small FIFO of classified operations between the front and back ends.
// ============================================================================
module lcd4_queue #(
    parameter int unsigned DEPTH = lcd4_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  lcd4_pkg::op_t        push_data,
    input  logic                 pop,
    output lcd4_pkg::op_t        pop_data,
    output lcd4_pkg::q_status_t  status
);
    import lcd4_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    op_t              slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == CNT_FULL);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_data     = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### hw/rtl/lcd4_back.sv
// ============================================================================
// lcd4_back
// Expands one operation into its enable pulses, one pulse per cycle.
// ============================================================================
module lcd4_back (
    input  logic                clk,
    input  logic                rst_n,
    input  lcd4_pkg::cfg_t      cfg,
    input  lcd4_pkg::q_status_t q_status,
    input  lcd4_pkg::op_t       op_in,
    output logic                pop,
    output lcd4_pkg::out_item_t result,
    output logic                result_strobe
);
    import lcd4_pkg::*;

    typedef enum logic [1:0] {
        BK_IDLE = 2'b01,
        BK_RUN  = 2'b10
    } back_state_t;

    back_state_t       state_reg, state_next;
    op_t               cur_reg, cur_next;
    logic [STEP_W-1:0] step_reg, step_next;
    out_item_t         result_reg, result_next;
    logic              strobe_reg, strobe_next;

    logic      is_last;
    logic      load;
    logic [2:0] cmd_idx;
    logic [7:0] init_byte;
    out_item_t pulse;

    assign is_last   = (cur_reg.op == OP_INIT) ? (step_reg == INIT_LAST_STEP)
                                               : (step_reg == BYTE_LAST_STEP);
    assign cmd_idx   = 3'(step_reg[STEP_W-1:1] - 3'd1);
    assign init_byte = init_cmd(cmd_idx);
    assign load      = !q_status.empty && ((state_reg == BK_IDLE) || is_last);
    assign pop       = load;

    // Pulse for the current step
    always_comb
    begin
        pulse.register_select  = cur_reg.register_select;
        pulse.settle_before_us = '0;
        pulse.enable_high_us   = cfg.enable_hold_us;
        pulse.settle_after_us  = '0;
        pulse.last             = is_last;
        pulse.nibble           = step_reg[0] ? cur_reg.byte_value[3:0]
                                             : cur_reg.byte_value[7:4];
        if (cur_reg.op == OP_INIT)
        begin
            pulse.register_select = 1'b0;
            if (step_reg == 4'd0)
            begin
                pulse.nibble           = INIT_NIBBLE_FIRST;
                pulse.settle_before_us = cfg.power_up_wait_us;
                pulse.enable_high_us   = '0;
                pulse.settle_after_us  = AFTER_FIRST_INIT_US;
            end
            else if (step_reg == 4'd1)
            begin
                pulse.nibble         = INIT_NIBBLE_SECOND;
                pulse.enable_high_us = '0;
            end
            else
            begin
                pulse.nibble          = step_reg[0] ? init_byte[3:0] : init_byte[7:4];
                pulse.settle_after_us = step_reg[0] ? cfg.init_step_wait_us : 16'd0;
            end
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cur_next    = cur_reg;
        step_next   = step_reg;
        result_next = result_reg;
        strobe_next = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (load)
                begin
                    cur_next   = op_in;
                    step_next  = '0;
                    state_next = BK_RUN;
                end
            end
            BK_RUN:
            begin
                result_next = pulse;
                strobe_next = 1'b1;
                if (is_last)
                begin
                    step_next = '0;
                    if (load)
                    begin
                        cur_next = op_in;
                    end
                    else
                    begin
                        state_next = BK_IDLE;
                    end
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= BK_IDLE;
            step_reg   <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            step_reg   <= step_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        result_reg <= result_next;
    end

    assign result        = result_reg;
    assign result_strobe = strobe_reg;

endmodule

### hw/rtl/char_lcd_4bit_write_sequencer.sv
// ============================================================================
// char_lcd_4bit_write_sequencer
// Write sequencer for a character LCD on a 4-bit bus (read/write held low).
// ============================================================================
// A request is taken at a clock edge with start high and busy low. Each
// request expands into a burst of enable pulses on result, one pulse per
// cycle with result_strobe high for exactly that cycle; the receiver cannot
// stall, so it must take every pulse as it appears. Init gives twelve pulses,
// command, data and cursor writes give two, and a cursor move to column 40 or
// beyond gives none. An accepted request is queued, loaded into the back end,
// and each of its pulses is registered onto result. Pulse output runs at one
// per cycle, set by the back end's step counter, back to back across requests
// while one waits in the short queue, and busy rises only while it is full.
// Configuration registers are written through wr_en/wr_index/wr_data and are
// sampled while pulses are generated, so change them only when idle.
// ============================================================================
module char_lcd_4bit_write_sequencer #(
    parameter int unsigned QUEUE_DEPTH = lcd4_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  lcd4_pkg::in_item_t                    request,
    output lcd4_pkg::out_item_t                   result,
    output logic                                  result_strobe,
    input  logic                                  wr_en,
    input  logic [lcd4_pkg::CFG_INDEX_W-1:0]      wr_index,
    input  logic [15:0]                           wr_data
);
    import lcd4_pkg::*;

    cfg_t      cfg_reg;
    q_status_t q_status;
    logic      push;
    op_t       push_data;
    logic      pop;
    op_t       pop_data;

    // Hold the three timing registers; an unused index writes nothing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable_hold_us    <= ENABLE_HOLD_RESET;
            cfg_reg.power_up_wait_us  <= POWER_UP_WAIT_RESET;
            cfg_reg.init_step_wait_us <= INIT_STEP_WAIT_RESET;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_ENABLE_HOLD:    cfg_reg.enable_hold_us    <= wr_data;
                REG_POWER_UP_WAIT:  cfg_reg.power_up_wait_us  <= wr_data;
                REG_INIT_STEP_WAIT: cfg_reg.init_step_wait_us <= wr_data;
                default:            cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Stall new requests only when the queue has no room
    assign busy = q_status.full;

    // Front end: classify the request and drop out-of-range cursor moves
    lcd4_front u_front (
        .start     (start),
        .busy      (busy),
        .request   (request),
        .push      (push),
        .push_data (push_data)
    );

    // Queue: decouple request intake from pulse generation
    lcd4_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .status    (q_status)
    );

    // Back end: advance through the pulses of each operation
    lcd4_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .q_status      (q_status),
        .op_in         (pop_data),
        .pop           (pop),
        .result        (result),
        .result_strobe (result_strobe)
    );

`ifndef ASSERT_OFF
    // A burst never breaks before its final pulse
    a_burst_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && !result.last |=> result_strobe)
        else $error("pulse burst broken before last pulse");

    // A data write is exactly two data-register pulses
    a_data_pair: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && result.register_select && !result.last
        |=> result_strobe && result.register_select && result.last)
        else $error("data write pulse pair malformed");

    // The queue cannot be empty and full at once
    a_queue_status: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_status.empty && q_status.full))
        else $error("queue reports both empty and full");
`endif

endmodule
